// ----- hw/rtl/fft_pkg.sv -----
// ----------------------------------------------------------------------------
// fft_pkg: shared types, constants and twiddle functions
// Holds the Q1.15 quarter-wave table, the saturating and rounding
// helpers and the sample record from the load front end to the engine.
// ----------------------------------------------------------------------------
package fft_pkg;

  localparam int MAX_PTS = 64;
  localparam int AW      = 6;
  localparam int DW      = 24;

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [16:0]   twid_t;

  // One loaded sample headed for the engine
  typedef struct packed {
    logic [AW-1:0]  addr;
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic           last;
  } load_beat_t;

  // Engine sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_P,
    ST_RD_O,
    ST_MUL,
    ST_SUM,
    ST_WR_O,
    ST_OUT
  } eng_state_t;

  // round(cos(2*pi*j/64) * 32767), j = 0..16
  function automatic logic [15:0] quarter_wave(input logic [4:0] j);
    case (j)
      5'd0:  quarter_wave = 16'd32767;
      5'd1:  quarter_wave = 16'd32609;
      5'd2:  quarter_wave = 16'd32137;
      5'd3:  quarter_wave = 16'd31356;
      5'd4:  quarter_wave = 16'd30273;
      5'd5:  quarter_wave = 16'd28898;
      5'd6:  quarter_wave = 16'd27245;
      5'd7:  quarter_wave = 16'd25329;
      5'd8:  quarter_wave = 16'd23170;
      5'd9:  quarter_wave = 16'd20787;
      5'd10: quarter_wave = 16'd18204;
      5'd11: quarter_wave = 16'd15446;
      5'd12: quarter_wave = 16'd12539;
      5'd13: quarter_wave = 16'd9512;
      5'd14: quarter_wave = 16'd6393;
      5'd15: quarter_wave = 16'd3212;
      default: quarter_wave = 16'd0;
    endcase
  endfunction

  // cos term of twiddle index j (period 64, only j < 32 used)
  function automatic twid_t tw_cos(input logic [4:0] j);
    logic [5:0] m;
    m = 6'd32 - {1'b0, j};
    if (j <= 5'd16) tw_cos = $signed({1'b0, quarter_wave(j)});
    else tw_cos = -$signed({1'b0, quarter_wave(m[4:0])});
  endfunction

  // -sin term of twiddle index j
  function automatic twid_t tw_nsin(input logic [4:0] j);
    logic [4:0] a;
    logic [4:0] b;
    a = 5'd16 - j;
    b = j - 5'd16;
    if (j <= 5'd16) tw_nsin = -$signed({1'b0, quarter_wave(a)});
    else tw_nsin = -$signed({1'b0, quarter_wave(b)});
  endfunction

  // Clamp a 26-bit value to 24 bits
  function automatic data_t sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) sat24 = 24'sh7FFFFF;
    else if (v < -26'sd8388608) sat24 = 24'sh800000;
    else sat24 = v[DW-1:0];
  endfunction

  // Rounded Q1.15 product: (a*w + 2^14) >>> 15
  function automatic logic signed [25:0] rnd15(input logic signed [40:0] p);
    logic signed [40:0] t;
    t = p + 41'sd16384;
    rnd15 = t[40:15];
  endfunction

endpackage

// ----- hw/rtl/fft_front.sv -----
// ----------------------------------------------------------------------------
// fft_front: sample intake
// Counts samples in a frame, tags each with its store address and the
// end-of-frame mark, and hands them on through a two-entry queue.
// ----------------------------------------------------------------------------
module fft_front #(
  parameter int LEN = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  in_re,
  input  logic signed [15:0]  in_im,
  output logic                q_valid,
  input  logic                q_take,
  output fft_pkg::load_beat_t q_beat
);
  import fft_pkg::*;

  logic [AW-1:0] cnt_r, cnt_nxt;
  load_beat_t    slot_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    fill_r;
  logic          acc, take;

  assign full    = (fill_r == 2'd2);
  assign acc     = push && !full;
  assign q_valid = (fill_r != 2'd0);
  assign take    = q_take && q_valid;
  assign q_beat  = slot_r[rp_r];

  // frame position
  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      if (cnt_r == AW'(LEN - 1)) cnt_nxt = '0;
      else cnt_nxt = cnt_r + 1'b1;
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) wp_r <= ~wp_r;
      if (take) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, acc} - {1'b0, take};
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (acc) begin
      slot_r[wp_r] <= '{addr: cnt_r, re: in_re, im: in_im,
                        last: (cnt_r == AW'(LEN - 1))};
    end
  end

endmodule

// ----- hw/rtl/fft_engine.sv -----
// ----------------------------------------------------------------------------
// fft_engine: butterfly sequencer, work memory and bin output
// Writes loaded samples bit-reversed, runs the stages with one shared
// butterfly unit, then streams the bins through a one-entry output register.
// ----------------------------------------------------------------------------
module fft_engine #(
  parameter int LEN  = 64,
  parameter int BITS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_take,
  input  fft_pkg::load_beat_t q_beat,
  output logic                empty,
  input  logic                pop,
  output logic signed [23:0]  bin_re,
  output logic signed [23:0]  bin_im,
  output logic                bin_last
);
  import fft_pkg::*;

  // butterflies per stage over the power-of-two part of the frame
  localparam int NBF = (1 << BITS) / 2;

  eng_state_t st_r, st_nxt;
  logic signed [DW-1:0] ram_re [MAX_PTS];
  logic signed [DW-1:0] ram_im [MAX_PTS];

  logic [2:0]    stg_r;       // stage 0..BITS-1
  logic [AW-1:0] bfly_r;      // butterfly number within stage
  logic [AW-1:0] ocnt_r;      // output address
  logic          ordv_r;      // output read pending
  logic          ov_r;        // output register full
  logic signed [DW-1:0] rd_re_r, rd_im_r;
  data_t         p_re_r, p_im_r, q_re, q_im;
  logic signed [40:0] m0_r, m1_r, m2_r, m3_r;
  logic          ostart_r;

  logic [AW-1:0] half, kk, base, pa, oa, twj, rev;
  twid_t         wc, ws;
  logic          we;
  logic [AW-1:0] wa;
  data_t         wd_re, wd_im;
  logic [AW-1:0] ra;
  logic          lastb;
  logic          can_rd;

  // butterfly addressing
  assign half  = AW'(1) << stg_r;
  assign kk    = bfly_r & (half - 1'b1);
  assign base  = (bfly_r & ~(half - 1'b1)) << 1;
  assign pa    = base + kk;
  assign oa    = pa + half;
  assign twj   = kk << (AW - 1 - stg_r);
  assign wc    = tw_cos(twj[4:0]);
  assign ws    = tw_nsin(twj[4:0]);
  assign lastb = (bfly_r == AW'(NBF - 1)) && (stg_r == 3'(BITS - 1));

  // bit reversal of the load address
  always_comb begin
    rev = '0;
    for (int b = 0; b < BITS; b++) rev[BITS-1-b] = q_beat.addr[b];
    if (int'(q_beat.addr) >= (1 << BITS)) rev = q_beat.addr;
  end

  assign q_take = (st_r == ST_LOAD);
  assign can_rd = !ordv_r && (!ov_r || pop) ;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD: if (q_valid && q_beat.last) st_nxt = (BITS == 0) ? ST_OUT : ST_RD_P;
      ST_RD_P: st_nxt = ST_RD_O;
      ST_RD_O: st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_WR_O;
      ST_WR_O: st_nxt = lastb ? ST_OUT : ST_RD_P;
      ST_OUT:  if (ordv_r && ocnt_r == AW'(LEN - 1) && !ostart_r) st_nxt = ST_LOAD;
      default: st_nxt = ST_LOAD;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = pa;
    wd_re = p_re_r;
    wd_im = p_im_r;
    ra = pa;
    case (st_r)
      ST_LOAD: begin
        we = q_valid;
        wa = rev;
        wd_re = DW'(q_beat.re);
        wd_im = DW'(q_beat.im);
      end
      ST_RD_O: ra = oa;
      ST_SUM: begin
        we = 1'b1;
        wa = pa;
        wd_re = sat24(26'(p_re_r) + 26'(q_re));
        wd_im = sat24(26'(p_im_r) + 26'(q_im));
      end
      ST_WR_O: begin
        we = 1'b1;
        wa = oa;
        wd_re = sat24(26'(p_re_r) - 26'(q_re));
        wd_im = sat24(26'(p_im_r) - 26'(q_im));
      end
      ST_OUT: ra = ocnt_r;
      default: ;
    endcase
  end

  // work memory
  always_ff @(posedge clk) begin
    if (we) begin
      ram_re[wa] <= wd_re;
      ram_im[wa] <= wd_im;
    end
    rd_re_r <= ram_re[ra];
    rd_im_r <= ram_im[ra];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ST_RD_O: begin
        p_re_r <= rd_re_r;
        p_im_r <= rd_im_r;
      end
      ST_MUL: begin
        m0_r <= rd_re_r * wc;
        m1_r <= rd_im_r * ws;
        m2_r <= rd_im_r * wc;
        m3_r <= rd_re_r * ws;
      end
      default: ;
    endcase
  end

  // twiddle combine, combinational from the registered products
  always_comb begin
    q_re = sat24(rnd15(m0_r) - rnd15(m1_r));
    q_im = sat24(rnd15(m2_r) + rnd15(m3_r));
  end

  // counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_LOAD;
      stg_r    <= '0;
      bfly_r   <= '0;
      ocnt_r   <= '0;
      ordv_r   <= 1'b0;
      ov_r     <= 1'b0;
      ostart_r <= 1'b1;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_WR_O) begin
        if (bfly_r == AW'(NBF - 1)) begin
          bfly_r <= '0;
          stg_r  <= lastb ? '0 : stg_r + 1'b1;
        end else begin
          bfly_r <= bfly_r + 1'b1;
        end
      end
      if (pop && ov_r) ov_r <= 1'b0;
      if (st_r == ST_OUT) begin
        if (ordv_r) begin
          ordv_r <= 1'b0;
          ov_r   <= 1'b1;
          bin_last <= (ocnt_r == AW'(LEN - 1));
          bin_re <= rd_re_r;
          bin_im <= rd_im_r;
          if (ocnt_r == AW'(LEN - 1)) begin
            ocnt_r   <= '0;
            ostart_r <= 1'b1;
          end else begin
            ocnt_r <= ocnt_r + 1'b1;
          end
        end else if (can_rd && !(ov_r && !pop)) begin
          ordv_r   <= 1'b1;
          ostart_r <= 1'b0;
        end
      end
    end
  end

  assign empty = !ov_r;

endmodule

// ----- hw/rtl/radix2_fft.sv -----
// ----------------------------------------------------------------------------
// radix2_fft: fixed-point radix-2 decimation-in-time forward FFT
// Loads POINTS (1..64) samples, transforms in place, streams the bins.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: present in_sample_re/in_sample_im with push; a beat is
//   taken when full is low. The front end buffers two samples.
//   Result queue: while empty is low the oldest bin is on out_bin_re,
//   out_bin_im and out_last_bin; pop takes it.
// Timing:
//   Loading takes one sample per cycle while the engine is in its load
//   state. The shared butterfly unit steps through five states per
//   butterfly (two memory reads, multiply, two writes); then the bins
//   are read one at a time through the single memory read port, and a
//   new frame is taken only after the last bin has been read.
//   Bins appear in natural order; last_bin marks the final one.
// Reset:
//   A synchronous low rst_n drops the frame position and all queues; the
//   work memory is not cleared, every entry is written before use.
// Stall:
//   A held-off pop keeps the bin in the output register and the engine
//   waits; the input side then fills and raises full.
// ----------------------------------------------------------------------------
module radix2_fft #(
  parameter int POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  in_sample_re,
  input  logic signed [15:0]  in_sample_im,
  output logic                empty,
  input  logic                pop,
  output logic signed [23:0]  out_bin_re,
  output logic signed [23:0]  out_bin_im,
  output logic                out_last_bin
);
  import fft_pkg::*;

  localparam int LEN  = (POINTS < 1) ? 1 : ((POINTS > 64) ? 64 : POINTS);
  localparam int BITS = (LEN >= 64) ? 6 : (LEN >= 32) ? 5 : (LEN >= 16) ? 4 :
                        (LEN >= 8) ? 3 : (LEN >= 4) ? 2 : (LEN >= 2) ? 1 : 0;

  logic       q_valid, q_take;
  load_beat_t q_beat;

  // sample intake
  fft_front #(.LEN(LEN)) u_front (
    .clk, .rst_n, .push, .full,
    .in_re(in_sample_re), .in_im(in_sample_im),
    .q_valid, .q_take, .q_beat
  );

  // transform and output
  fft_engine #(.LEN(LEN), .BITS(BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_take, .q_beat,
    .empty, .pop,
    .bin_re(out_bin_re), .bin_im(out_bin_im), .bin_last(out_last_bin)
  );

endmodule
